// ===== design/adjacency_text_two_hop_neighbors_macros.svh =====
// assertion macros shared by the checker of the two-hop neighbor block
// depends on nothing; included by design/thn_check.sv
`ifndef ADJACENCY_TEXT_TWO_HOP_NEIGHBORS_MACROS_SVH
`define ADJACENCY_TEXT_TWO_HOP_NEIGHBORS_MACROS_SVH

// same-cycle implication under reset
`define THN_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("thn check failed");

// next-cycle implication under reset
`define THN_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("thn check failed");

`endif

// ===== design/thn_pkg.sv =====
// types and constants of the two-hop neighbor block
// depends on nothing; used by thn_ctrl, thn_dp and the top level
package thn_pkg;

  // input actions
  localparam logic [1:0] ACT_TEXT  = 2'd0;
  localparam logic [1:0] ACT_EOT   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_VERTS = 3'd2;
  localparam logic [2:0] ST_EDGES = 3'd3;
  localparam logic [2:0] ST_QUERY = 3'd4;

  // text characters
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [15:0] ACC_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EOT_CLOSE,
    S_EOT_DONE,
    S_Q_CHECK,
    S_Q_OUTER_SET,
    S_Q_OUTER,
    S_Q_NBR,
    S_Q_INNER_SET,
    S_Q_INNER,
    S_Q_MEMB,
    S_Q_FLUSH,
    S_Q_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic parse;
    logic eot_close;
    logic eot_finish;
    logic take_query;
    logic bad_emit;
    logic q_start;
    logic outer_set;
    logic outer_read;
    logic nbr_take;
    logic inner_set;
    logic inner_read;
    logic memb_take;
    logic emit_empty;
    logic scan_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_bad;
    logic j_more;
    logic k_more;
    logic mask_empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/thn_ctrl.sv =====
// sequencer of the two-hop neighbor block: load, end of text and query walk
// depends on thn_pkg
module thn_ctrl import thn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_EOT:   state_next = S_EOT_CLOSE;
            ACT_QUERY: state_next = S_Q_CHECK;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_EOT_CLOSE:   state_next = S_EOT_DONE;
      S_EOT_DONE:    if (sts.out_free) state_next = S_IDLE;
      S_Q_CHECK: begin
        if (!sts.q_bad) state_next = S_Q_OUTER_SET;
        else if (sts.out_free) state_next = S_IDLE;
      end
      S_Q_OUTER_SET: state_next = S_Q_OUTER;
      S_Q_OUTER:     state_next = sts.j_more ? S_Q_NBR : S_Q_FLUSH;
      S_Q_NBR:       state_next = S_Q_INNER_SET;
      S_Q_INNER_SET: state_next = S_Q_INNER;
      S_Q_INNER:     state_next = sts.k_more ? S_Q_MEMB : S_Q_OUTER;
      S_Q_MEMB:      state_next = S_Q_INNER;
      S_Q_FLUSH: begin
        if (!sts.mask_empty) state_next = S_Q_SCAN;
        else if (sts.out_free) state_next = S_IDLE;
      end
      S_Q_SCAN:      if (sts.out_free && sts.scan_last) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.parse      = (state == S_IDLE) && accept && (action == ACT_TEXT);
    cmd.take_query = (state == S_IDLE) && accept && (action == ACT_QUERY);
    cmd.eot_close  = (state == S_EOT_CLOSE);
    cmd.eot_finish = (state == S_EOT_DONE) && sts.out_free;
    cmd.bad_emit   = (state == S_Q_CHECK) && sts.q_bad && sts.out_free;
    cmd.q_start    = (state == S_Q_CHECK) && !sts.q_bad;
    cmd.outer_set  = (state == S_Q_OUTER_SET);
    cmd.outer_read = (state == S_Q_OUTER) && sts.j_more;
    cmd.nbr_take   = (state == S_Q_NBR);
    cmd.inner_set  = (state == S_Q_INNER_SET);
    cmd.inner_read = (state == S_Q_INNER) && sts.k_more;
    cmd.memb_take  = (state == S_Q_MEMB);
    cmd.emit_empty = (state == S_Q_FLUSH) && sts.mask_empty && sts.out_free;
    cmd.scan_step  = (state == S_Q_SCAN) && sts.out_free;
  end

endmodule

// ===== design/thn_dp.sv =====
// datapath of the two-hop neighbor block: parser, adjacency and list-start
// memories, reach mask and output register; depends on thn_pkg
module thn_dp import thn_pkg::*; #(
  parameter int VERTICES = 64,
  parameter int EDGES    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  text_byte,
  input  logic [5:0]  query_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [5:0]  neighbor_id,
  output logic        is_last,
  output logic        list_empty,
  output logic [6:0]  vertex_total,
  output logic [10:0] edge_total,
  output logic [2:0]  status
);

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int LW = $clog2(VERTICES + 1);
  localparam int AW = $clog2(EDGES);
  localparam int EW = $clog2(EDGES + 1);
  localparam logic [VERTICES-1:0] BIT0 = VERTICES'(1);

  // load state
  logic [15:0] acc, acc_next;
  logic        line_empty, empty_next;
  logic        stopped, stopped_next;
  logic [LW-1:0] lines, lines_next;
  logic [EW-1:0] entries, entries_next;
  logic [VW-1:0] largest, largest_next;
  logic        loaded, loaded_next;
  logic [2:0]  err, err_next;

  // memories
  logic [VW-1:0] adj_mem [EDGES];
  logic [EW-1:0] ls_mem [VERTICES + 1];
  logic          adj_we, ls_we;
  logic [AW-1:0] adj_raddr;
  logic [VW-1:0] adj_rd;
  logic [LW-1:0] ls_raddr, ls_raddr_b;
  logic [EW-1:0] ls_rd_a, ls_rd_b;

  // query state
  logic [5:0]          v_reg;
  logic [EW-1:0]       j, jend, k, kend;
  logic [VERTICES-1:0] mask, mask_rest;
  logic [VW-1:0]       idx;
  logic                scan_hit, load_out;

  // parser and end-of-text bookkeeping
  logic        text_on, do_close, do_store, is_digit;
  logic [19:0] digit_sum;

  always_comb begin
    acc_next     = acc;
    empty_next   = line_empty;
    stopped_next = stopped;
    lines_next   = lines;
    entries_next = entries;
    largest_next = largest;
    loaded_next  = loaded;
    err_next     = err;
    adj_we       = 1'b0;
    ls_we        = 1'b0;
    text_on   = cmd.parse && !loaded && !stopped;
    is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    digit_sum = 20'(acc) * 20'd10 + 20'(text_byte[3:0]);
    do_close  = (text_on && text_byte == CH_NL) || (cmd.eot_close && !loaded);
    do_store  = (text_on && text_byte == CH_SP) || (do_close && !line_empty);
    // store the pending number
    if (do_store) begin
      if (acc >= 16'(VERTICES)) begin
        if (err_next == ST_OK) err_next = ST_RANGE;
      end else if (entries >= EW'(EDGES)) begin
        if (err_next == ST_OK) err_next = ST_EDGES;
      end else begin
        adj_we       = 1'b1;
        entries_next = entries + 1'b1;
        if (acc[VW-1:0] > largest) largest_next = acc[VW-1:0];
      end
    end
    // close the line
    if (do_close) begin
      if (lines >= LW'(VERTICES)) begin
        if (err_next == ST_OK) err_next = ST_VERTS;
      end else begin
        lines_next = lines + 1'b1;
        ls_we      = 1'b1;
      end
      acc_next   = '0;
      empty_next = 1'b1;
    end
    if (text_on && text_byte == CH_SP) acc_next = '0;
    if (text_on && text_byte == CH_NUL) stopped_next = 1'b1;
    if (text_on && is_digit) begin
      acc_next   = (digit_sum > 20'(ACC_MAX)) ? ACC_MAX : digit_sum[15:0];
      empty_next = 1'b0;
    end
    // dangling id check at end of text
    if (cmd.eot_finish && !loaded) begin
      if (entries != '0 && LW'(largest) >= lines && err_next == ST_OK) begin
        err_next = ST_RANGE;
      end
      loaded_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      line_empty <= 1'b1;
      stopped    <= 1'b0;
      lines      <= '0;
      entries    <= '0;
      largest    <= '0;
      loaded     <= 1'b0;
      err        <= ST_OK;
    end else begin
      acc        <= acc_next;
      line_empty <= empty_next;
      stopped    <= stopped_next;
      lines      <= lines_next;
      entries    <= entries_next;
      largest    <= largest_next;
      loaded     <= loaded_next;
      err        <= err_next;
    end
  end

  // adjacency memory
  assign adj_raddr = cmd.outer_read ? j[AW-1:0] : k[AW-1:0];

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[entries[AW-1:0]] <= acc[VW-1:0];
    adj_rd <= adj_mem[adj_raddr];
  end

  // list-start memory, entry zero reads as zero
  assign ls_raddr   = cmd.nbr_take ? LW'(adj_rd) : LW'(v_reg);
  assign ls_raddr_b = ls_raddr + 1'b1;

  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[lines_next] <= entries_next;
    ls_rd_a <= (ls_raddr == '0) ? '0 : ls_mem[ls_raddr];
    ls_rd_b <= ls_mem[ls_raddr_b];
  end

  // query walk
  always_ff @(posedge clk) begin
    if (cmd.take_query) v_reg <= query_vertex;
    if (cmd.q_start) begin
      mask <= '0;
      idx  <= '0;
    end
    if (cmd.outer_set) begin
      j    <= ls_rd_a;
      jend <= ls_rd_b;
    end
    if (cmd.outer_read) j <= j + 1'b1;
    if (cmd.nbr_take) mask[adj_rd] <= 1'b1;
    if (cmd.inner_set) begin
      k    <= ls_rd_a;
      kend <= ls_rd_b;
    end
    if (cmd.inner_read) k <= k + 1'b1;
    if (cmd.memb_take && adj_rd != v_reg[VW-1:0]) mask[adj_rd] <= 1'b1;
    if (cmd.scan_step) begin
      mask[idx] <= 1'b0;
      idx       <= idx + 1'b1;
    end
  end

  // status to the controller
  assign scan_hit  = mask[idx];
  assign mask_rest = mask & ~(BIT0 << idx);

  always_comb begin
    sts.q_bad      = !loaded || (err != ST_OK) || (7'(v_reg) >= 7'(lines));
    sts.j_more     = (j < jend);
    sts.k_more     = (k < kend);
    sts.mask_empty = (mask == '0);
    sts.scan_last  = scan_hit && (mask_rest == '0);
    sts.out_free   = !out_valid || out_ready;
  end

  // output register
  assign load_out = cmd.eot_finish || cmd.bad_emit || cmd.emit_empty ||
                    (cmd.scan_step && scan_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload, one full assignment per kind of beat
  always_ff @(posedge clk) begin
    if (load_out) begin
      priority if (cmd.eot_finish) begin
        result_kind  <= 1'b0;
        neighbor_id  <= '0;
        is_last      <= 1'b1;
        list_empty   <= 1'b0;
        vertex_total <= 7'(lines);
        edge_total   <= 11'(entries);
        status       <= err_next;
      end else if (cmd.bad_emit) begin
        result_kind  <= 1'b0;
        neighbor_id  <= '0;
        is_last      <= 1'b1;
        list_empty   <= 1'b0;
        vertex_total <= '0;
        edge_total   <= '0;
        status       <= ST_QUERY;
      end else if (cmd.emit_empty) begin
        result_kind  <= 1'b0;
        neighbor_id  <= '0;
        is_last      <= 1'b1;
        list_empty   <= 1'b1;
        vertex_total <= '0;
        edge_total   <= '0;
        status       <= ST_OK;
      end else begin
        result_kind  <= 1'b1;
        neighbor_id  <= 6'(idx);
        is_last      <= (mask_rest == '0);
        list_empty   <= 1'b0;
        vertex_total <= '0;
        edge_total   <= '0;
        status       <= ST_OK;
      end
    end
  end

endmodule

// ===== design/adjacency_text_two_hop_neighbors.sv =====
// top level of the two-hop neighbor block: controller plus datapath
// depends on thn_pkg, thn_ctrl and thn_dp
//
//   channel | handshake           | payload
//   in      | in_valid / in_ready | action, text_byte, query_vertex
//   out     | out_valid/out_ready | result_kind, neighbor_id, is_last, list_empty,
//           |                     | vertex_total, edge_total, status
//
// end of text closes the last line, then emits one status beat with the totals
// a query walks the list of the vertex and of each neighbor, one memory read per
// adjacency entry, then scans ids from zero through the highest set id of the reach
// mask (at most VERTICES); a bad query emits only its status beat
// rst is synchronous and clears the control state; memories have no clearing pass
// in_ready is low while an end of text or a query is in progress; out_ready low holds
// the output register and stalls the scan
module adjacency_text_two_hop_neighbors import thn_pkg::*; #(
  parameter int VERTICES = 64,
  parameter int EDGES    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  text_byte,
  input  logic [5:0]  query_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [5:0]  neighbor_id,
  output logic        is_last,
  output logic        list_empty,
  output logic [6:0]  vertex_total,
  output logic [10:0] edge_total,
  output logic [2:0]  status
);

  cmd_t cmd;
  sts_t sts;

  thn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  thn_dp #(
    .VERTICES (VERTICES),
    .EDGES    (EDGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .text_byte    (text_byte),
    .query_vertex (query_vertex),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .neighbor_id  (neighbor_id),
    .is_last      (is_last),
    .list_empty   (list_empty),
    .vertex_total (vertex_total),
    .edge_total   (edge_total),
    .status       (status)
  );

endmodule

// ===== design/thn_check.sv =====
// port-level checker of the two-hop neighbor block and its bind
// depends on thn_pkg and adjacency_text_two_hop_neighbors_macros.svh
`include "adjacency_text_two_hop_neighbors_macros.svh"

module thn_check import thn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [5:0]  neighbor_id,
  input logic        is_last,
  input logic        list_empty,
  input logic [6:0]  vertex_total,
  input logic [10:0] edge_total,
  input logic [2:0]  status
);

  // a stalled beat holds
  `THN_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(neighbor_id) && $stable(status))
  // status items carry no neighbor id
  `THN_IMPLY(a_status_id, clk, rst, out_valid && !result_kind, neighbor_id == 6'd0 && is_last)
  // entries carry no status or totals
  `THN_IMPLY(a_entry_clean, clk, rst, out_valid && result_kind, status == ST_OK && vertex_total == 7'd0 && edge_total == 11'd0 && !list_empty)
  // an empty set is a plain ok status item
  `THN_IMPLY(a_empty_ok, clk, rst, out_valid && list_empty, !result_kind && status == ST_OK)
  // a bad query reports no totals
  `THN_IMPLY(a_bad_query, clk, rst, out_valid && status == ST_QUERY, vertex_total == 7'd0 && edge_total == 11'd0)

endmodule

bind adjacency_text_two_hop_neighbors thn_check u_thn_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .neighbor_id  (neighbor_id),
  .is_last      (is_last),
  .list_empty   (list_empty),
  .vertex_total (vertex_total),
  .edge_total   (edge_total),
  .status       (status)
);

// ===== dv/adjacency_text_two_hop_neighbors_tb.sv =====
// testbench of the two-hop neighbor block: loads one graph as text, then queries it
// depends on thn_pkg and the adjacency_text_two_hop_neighbors top level
`timescale 1ns / 100ps

module adjacency_text_two_hop_neighbors_tb import thn_pkg::*; ();

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam int NV = 64;
  localparam int NE = 1024;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct packed {
    logic        kind;
    logic [5:0]  id;
    logic        last;
    logic        empty;
    logic [6:0]  vt;
    logic [10:0] et;
    logic [2:0]  st;
  } beat_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] chr;
    logic [5:0] vtx;
    bit         typed;
    beat_t      want;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [7:0]  text_byte = '0;
  logic [5:0]  query_vertex = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        result_kind;
  logic [5:0]  neighbor_id;
  logic        is_last;
  logic        list_empty;
  logic [6:0]  vertex_total;
  logic [10:0] edge_total;
  logic [2:0]  status;

  adjacency_text_two_hop_neighbors dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor copy of the graph loader state
  logic [5:0] nbr_mem [NE];
  int         row_base [NV + 1];
  int         acc, n_lines, n_entries, top_id, load_err;
  bit         blank_line, halted, loaded;

  beat_t pending_results[$];
  int    errors = 0;
  int    send_gap_pct = 0;
  int    stall_pct = 0;
  int    idle_count = 0;
  bit    draining = 0;

  task automatic report(input string what);
    begin
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    end
  endtask

  function automatic void flag(input int code);
    if (load_err == 0) load_err = code;
  endfunction

  function automatic void keep_number();
    if (acc >= NV) flag(ST_RANGE);
    else if (n_entries >= NE) flag(ST_EDGES);
    else begin
      nbr_mem[n_entries] = acc[5:0];
      n_entries++;
      if (acc > top_id) top_id = acc;
    end
  endfunction

  function automatic void end_line();
    if (!blank_line) keep_number();
    if (n_lines >= NV) flag(ST_VERTS);
    else begin
      n_lines++;
      row_base[n_lines] = n_entries;
    end
    acc = 0;
    blank_line = 1;
  endfunction

  function automatic beat_t mk(input logic kind, input logic [5:0] id, input logic last,
                               input logic empty, input int vt, input int et,
                               input logic [2:0] st);
    beat_t b;
    b.kind = kind; b.id = id; b.last = last; b.empty = empty;
    b.vt = vt[6:0]; b.et = et[10:0]; b.st = st;
    return b;
  endfunction

  // expected beats of one accepted input
  function automatic void predict_two_hop(input logic [1:0] a, input logic [7:0] c,
                                          input logic [5:0] v);
    logic [63:0] reach;
    int n;
    case (a)
      ACT_TEXT: begin
        if (!loaded && !halted) begin
          if (c == CH_NL) end_line();
          else if (c == CH_SP) begin
            keep_number();
            acc = 0;
          end else if (c == CH_NUL) halted = 1;
          else if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = acc * 10 + (c - CH_ZERO);
            if (acc > ACC_MAX) acc = ACC_MAX;
            blank_line = 0;
          end
        end
      end
      ACT_EOT: begin
        if (!loaded) begin
          end_line();
          if (n_entries > 0 && top_id >= n_lines) flag(ST_RANGE);
          loaded = 1;
        end
        pending_results.push_back(mk(0, 0, 1, 0, n_lines, n_entries, load_err[2:0]));
      end
      ACT_QUERY: begin
        if (!loaded || load_err != 0 || v >= n_lines)
          pending_results.push_back(mk(0, 0, 1, 0, 0, 0, ST_QUERY));
        else begin
          reach = '0;
          for (int j = row_base[v]; j < row_base[v + 1]; j++) begin
            n = nbr_mem[j];
            reach[n] = 1;
            for (int k = row_base[n]; k < row_base[n + 1]; k++)
              if (nbr_mem[k] != v) reach[nbr_mem[k]] = 1;
          end
          if (reach == '0) pending_results.push_back(mk(0, 0, 1, 1, 0, 0, ST_OK));
          else
            for (int i = 0; i < 64; i++)
              if (reach[i])
                pending_results.push_back(mk(1, i, (reach >> (i + 1)) == '0, 0, 0, 0,
                                             ST_OK));
        end
      end
      default: ;
    endcase
  endfunction

  // one input beat with a random gap in front
  task automatic send(input logic [1:0] a, input logic [7:0] c, input logic [5:0] v);
    begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid = 0;
        @(negedge clk);
      end
      in_valid = 1;
      action = a;
      text_byte = c;
      query_vertex = v;
      do @(posedge clk); while (!in_ready);
      predict_two_hop(a, c, v);
      @(negedge clk);
    end
  endtask

  // idling phases in rotation
  task automatic pick_phase(input int phase);
    begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 50; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 50; end
        default: begin send_gap_pct = 33; stall_pct = 33; end
      endcase
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (!rst) out_ready <= draining ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {result_kind, neighbor_id, is_last, list_empty, vertex_total, edge_total,
             status};
      if (pending_results.size() == 0) report("result with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report("result_kind");
        if (got.id !== want.id) report("neighbor_id");
        if (got.last !== want.last) report("is_last");
        if (got.empty !== want.empty) report("list_empty");
        if (got.vt !== want.vt) report("vertex_total");
        if (got.et !== want.et) report("edge_total");
        if (got.st !== want.st) report("status");
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("FAIL adjacency_text_two_hop_neighbors");
      $finish;
    end
  end

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = $urandom_range(255);
    while (c == CH_NL || c == CH_SP || c == CH_NUL || (c >= CH_ZERO && c <= CH_NINE));
    return c;
  endfunction

  // text of one id, sometimes with a leading zero or a stray byte
  task automatic push_id(ref logic [7:0] txt[$], input int id);
    string s;
    begin
      s = $sformatf("%0d", id);
      if ($urandom_range(9) == 0) txt.push_back(CH_ZERO);
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      if ($urandom_range(9) == 0) txt.push_back($urandom_range(1) ? CH_CR : noise_char());
    end
  endtask

  row_t       directed[$];
  logic [7:0] load_text[$];
  int         beats = 0;
  int         r;

  initial begin
    acc = 0; n_lines = 0; n_entries = 0; top_id = 0; load_err = 0;
    blank_line = 1; halted = 0; loaded = 0;
    row_base[0] = 0;

    // queries before end of text are refused; stray bytes do nothing
    directed.push_back('{ACT_QUERY, 8'h00, 6'd0, 1, mk(0, 0, 1, 0, 0, 0, ST_QUERY)});
    directed.push_back('{ACT_QUERY, 8'hFF, 6'd63, 1, mk(0, 0, 1, 0, 0, 0, ST_QUERY)});
    directed.push_back('{ACT_UNUSED, 8'h55, 6'd21, 0, '0});
    directed.push_back('{ACT_TEXT, 8'hFF, 6'd42, 0, '0});
    directed.push_back('{ACT_TEXT, CH_CR, 6'd0, 0, '0});
    directed.push_back('{ACT_TEXT, 8'hAA, 6'd0, 0, '0});

    // vertex 0 lists every id, so its set is the whole range
    for (int i = 0; i < NV; i++) begin
      push_id(load_text, i);
      load_text.push_back(CH_SP);
    end
    load_text.push_back(CH_NL);
    // 62 more short lines, some empty; end of text adds an empty last line
    for (int l = 1; l < NV - 1; l++) begin
      r = $urandom_range(2);
      for (int e = 0; e < r; e++) begin
        if (e > 0) load_text.push_back(CH_SP);
        if ($urandom_range(19) == 0) load_text.push_back(CH_SP);
        push_id(load_text, $urandom_range(NV - 1));
      end
      if ($urandom_range(5) == 0) load_text.push_back(CH_CR);
      load_text.push_back(CH_NL);
    end
    // text after a NUL is dead
    load_text.push_back(CH_NUL);
    load_text.push_back("7");
    load_text.push_back(CH_SP);
    load_text.push_back(CH_NL);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed table
    foreach (directed[i]) begin
      pick_phase(beats++ / 120);
      if (directed[i].typed) begin
        send(directed[i].act, directed[i].chr, directed[i].vtx);
        if (pending_results.size() == 0 || pending_results[$] !== directed[i].want)
          report($sformatf("directed row %0d prediction", i));
      end else send(directed[i].act, directed[i].chr, directed[i].vtx);
    end

    // graph load, repeated end of text, then the special queries
    foreach (load_text[i]) begin
      pick_phase(beats++ / 120);
      send(ACT_TEXT, load_text[i], $urandom_range(63));
    end
    send(ACT_EOT, $urandom_range(255), $urandom_range(63));
    send(ACT_EOT, 8'h00, 6'd0);
    send(ACT_TEXT, 8'h31, 6'd0);
    send(ACT_QUERY, 8'h00, 6'd63);
    if (pending_results[$] !== mk(0, 0, 1, 1, 0, 0, ST_OK)) report("empty last vertex");
    send(ACT_QUERY, 8'h00, 6'd0);

    // random queries with some noise, every idling phase in turn
    for (int i = 0; i < 60; i++) begin
      pick_phase(i / 15);
      r = $urandom_range(99);
      if (r < 85) send(ACT_QUERY, $urandom_range(255), $urandom_range(63));
      else if (r < 92) send(ACT_UNUSED, $urandom_range(255), $urandom_range(63));
      else send(ACT_TEXT, $urandom_range(255), $urandom_range(63));
    end
    in_valid = 0;

    // drain and let the block settle
    draining = 1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("PASS adjacency_text_two_hop_neighbors");
    else
      $display("FAIL adjacency_text_two_hop_neighbors");
    $finish;
  end

endmodule
